>>> rtl/tcra_pkg.sv
// Shared types and constants for the two-context register ALU.
// Holds opcode, status and item-kind codes and the queue entry layout.
// No dependencies; every other file of the block refers to it by scoped names.
package tcra_pkg;

    // Fixed widths of the transaction fields.
    localparam int OP_W   = 4;
    localparam int IDX_W  = 5;
    localparam int WORD_W = 32;

    // Number of distinct values of a register index field.
    localparam int IDX_RANGE = 32;

    // Width of the multiplier operand slice handled per cycle.
    localparam int MUL_CHUNK = 16;

    // Default configuration of the block.
    localparam int DEF_NUM_REGS     = 32;
    localparam int DEF_NUM_CONTEXTS = 2;
    localparam int DEF_DATA_WIDTH   = 32;
    localparam int DEF_QUEUE_DEPTH  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_ADDI = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_AND  = 4'd4,
        OP_OR   = 4'd5,
        OP_ORI  = 4'd6,
        OP_XOR  = 4'd7,
        OP_SLL  = 4'd8,
        OP_SRL  = 4'd9,
        OP_LI   = 4'd10,
        OP_DUMP = 4'd11,
        OP_NOP  = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        STATUS_EXEC = 2'd0,
        STATUS_DUMP = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DUMP  = 2'd1,
        KIND_NOP   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    // One classified instruction as it waits between front and back end.
    // Register indexes are already wrapped to the register file size.
    typedef struct packed {
        kind_t              kind;
        op_t                op;
        logic               ctx;
        logic [IDX_W-1:0]   dest;
        logic [IDX_W-1:0]   src_a;
        logic [IDX_W-1:0]   src_b;
        logic [WORD_W-1:0]  imm;
    } entry_t;

endpackage

>>> rtl/tcra_if.sv
// Valid/ready channel interfaces for instruction and result transactions.
// Depends on tcra_pkg for the field widths.
interface tcra_in_if;
    logic                             valid;
    logic                             ready;
    logic [tcra_pkg::OP_W-1:0]        op;
    logic                             context_req;
    logic [tcra_pkg::IDX_W-1:0]       dest_reg;
    logic [tcra_pkg::IDX_W-1:0]       src_a_reg;
    logic [tcra_pkg::IDX_W-1:0]       src_b_reg;
    logic signed [tcra_pkg::WORD_W-1:0] immediate;

    modport source (
        output valid, op, context_req, dest_reg, src_a_reg, src_b_reg, immediate,
        input  ready
    );
    modport sink (
        input  valid, op, context_req, dest_reg, src_a_reg, src_b_reg, immediate,
        output ready
    );
endinterface

interface tcra_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [tcra_pkg::IDX_W-1:0]         reg_index;
    logic signed [tcra_pkg::WORD_W-1:0] reg_value;
    logic                               last;

    modport source (
        output valid, status, reg_index, reg_value, last,
        input  ready
    );
    modport sink (
        input  valid, status, reg_index, reg_value, last,
        output ready
    );
endinterface

>>> rtl/tcra_front.sv
// Front end: accepts instruction transactions, classifies the opcode and
// wraps the context and register indexes. Depends on tcra_pkg and tcra_in_if.
module tcra_front #(
    parameter int NUM_REGS     = tcra_pkg::DEF_NUM_REGS,
    parameter int NUM_CONTEXTS = tcra_pkg::DEF_NUM_CONTEXTS
) (
    tcra_in_if.sink            instr,
    input  logic               q_full,
    input  logic               clearing,
    output logic               push,
    output tcra_pkg::entry_t   push_entry
);

    localparam int IW = tcra_pkg::IDX_W;

    // Maps every possible index field value onto the register file size.
    function automatic logic [tcra_pkg::IDX_RANGE-1:0][IW-1:0] wrap_table();
        logic [tcra_pkg::IDX_RANGE-1:0][IW-1:0] tbl;
        logic [IW-1:0]                          j;
        j = '0;
        for (int i = 0; i < tcra_pkg::IDX_RANGE; i++)
        begin
            tbl[i] = j;
            if (int'(j) == NUM_REGS - 1)
            begin
                j = '0;
            end
            else
            begin
                j = j + 1'b1;
            end
        end
        return tbl;
    endfunction

    localparam logic [tcra_pkg::IDX_RANGE-1:0][IW-1:0] WRAP = wrap_table();

    assign instr.ready = !q_full && !clearing;
    assign push        = instr.valid && instr.ready;

    always_comb
    begin
        push_entry.ctx   = (NUM_CONTEXTS > 1) ? instr.context_req : 1'b0;
        push_entry.dest  = WRAP[instr.dest_reg];
        push_entry.src_a = WRAP[instr.src_a_reg];
        push_entry.src_b = WRAP[instr.src_b_reg];
        push_entry.imm   = instr.immediate;
        push_entry.op    = tcra_pkg::OP_NOP;
        push_entry.kind  = tcra_pkg::KIND_BAD;
        case (instr.op)
            tcra_pkg::OP_ADD, tcra_pkg::OP_ADDI, tcra_pkg::OP_SUB, tcra_pkg::OP_MUL,
            tcra_pkg::OP_AND, tcra_pkg::OP_OR, tcra_pkg::OP_ORI, tcra_pkg::OP_XOR,
            tcra_pkg::OP_SLL, tcra_pkg::OP_SRL, tcra_pkg::OP_LI:
            begin
                push_entry.kind = tcra_pkg::KIND_WRITE;
                push_entry.op   = tcra_pkg::op_t'(instr.op);
            end
            tcra_pkg::OP_DUMP:
            begin
                push_entry.kind = tcra_pkg::KIND_DUMP;
            end
            tcra_pkg::OP_NOP:
            begin
                push_entry.kind = tcra_pkg::KIND_NOP;
            end
            default:
            begin
                push_entry.kind = tcra_pkg::KIND_BAD;
            end
        endcase
    end

endmodule

>>> rtl/tcra_queue.sv
// Short first-in first-out queue of classified instructions between the
// front and back end. Depends on tcra_pkg for the entry layout.
module tcra_queue #(
    parameter int DEPTH = tcra_pkg::DEF_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tcra_pkg::entry_t   push_entry,
    output logic               full,
    input  logic               pop,
    output tcra_pkg::entry_t   head,
    output logic               empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    tcra_pkg::entry_t slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/tcra_back.sv
// Back end: register file memory, ALU, chunked multiplier, dump sequencer
// and output register. Depends on tcra_pkg and tcra_out_if.
module tcra_back #(
    parameter int NUM_REGS     = tcra_pkg::DEF_NUM_REGS,
    parameter int NUM_CONTEXTS = tcra_pkg::DEF_NUM_CONTEXTS,
    parameter int DATA_WIDTH   = tcra_pkg::DEF_DATA_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  tcra_pkg::entry_t   q_head,
    output logic               q_pop,
    output logic               clearing,
    tcra_out_if.source         result
);

    localparam int DEPTH  = NUM_CONTEXTS * NUM_REGS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RIW    = $clog2(NUM_REGS);
    localparam int MC     = tcra_pkg::MUL_CHUNK;
    localparam int NCHUNK = (DATA_WIDTH + MC - 1) / MC;
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int WIDE_W = NCHUNK * MC;
    localparam int IW     = tcra_pkg::IDX_W;
    localparam int WW     = tcra_pkg::WORD_W;

    localparam logic [AW-1:0]  ROW_STRIDE = AW'(NUM_REGS);
    localparam logic [AW-1:0]  LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [RIW-1:0] LAST_IDX   = RIW'(NUM_REGS - 1);
    localparam logic [CKW-1:0] LAST_CHUNK = CKW'(NCHUNK - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_MUL   = 6'b001000,
        S_WB    = 6'b010000,
        S_DUMP  = 6'b100000
    } state_t;

    function automatic logic [AW-1:0] rf_addr(input logic ctx, input logic [RIW-1:0] idx);
        return (ctx ? ROW_STRIDE : '0) + AW'(idx);
    endfunction

    state_t                  state_reg, state_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [RIW-1:0]          dump_idx_reg, dump_idx_next;
    logic [CKW-1:0]          chunk_reg, chunk_next;
    tcra_pkg::entry_t        cur_reg, cur_next;
    logic [DATA_WIDTH-1:0]   res_reg, res_next;
    logic [DATA_WIDTH-1:0]   mcand_reg, mcand_next;

    logic [DATA_WIDTH-1:0]   rf_mem [DEPTH];
    logic [DATA_WIDTH-1:0]   rd_a_reg, rd_b_reg;
    logic                    mem_we, rd_en;
    logic [AW-1:0]           mem_waddr, rd_addr_a, rd_addr_b;
    logic [DATA_WIDTH-1:0]   mem_wdata;

    logic                    out_valid_reg;
    tcra_pkg::status_t       out_status_reg, out_status_next;
    logic [IW-1:0]           out_index_reg, out_index_next;
    logic [WW-1:0]           out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_load, out_free;

    logic [DATA_WIDTH-1:0]   imm_dw;
    logic [4:0]              shamt;
    logic [DATA_WIDTH-1:0]   alu_res;
    logic [WIDE_W-1:0]       vb_wide;
    logic [MC-1:0]           chunk_sel;
    logic [DATA_WIDTH+MC-1:0] prod;

    assign clearing = (state_reg == S_CLEAR);
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid     = out_valid_reg;
    assign result.status    = out_status_reg;
    assign result.reg_index = out_index_reg;
    assign result.reg_value = out_value_reg;
    assign result.last      = out_last_reg;

    // Immediate is sign-extended from the field, then fitted to the data width.
    assign imm_dw = DATA_WIDTH'(signed'(cur_reg.imm));
    assign shamt  = cur_reg.imm[4:0];

    always_comb
    begin
        case (cur_reg.op)
            tcra_pkg::OP_ADD:  alu_res = rd_a_reg + rd_b_reg;
            tcra_pkg::OP_ADDI: alu_res = rd_a_reg + imm_dw;
            tcra_pkg::OP_SUB:  alu_res = rd_a_reg - rd_b_reg;
            tcra_pkg::OP_AND:  alu_res = rd_a_reg & rd_b_reg;
            tcra_pkg::OP_OR:   alu_res = rd_a_reg | rd_b_reg;
            tcra_pkg::OP_ORI:  alu_res = rd_a_reg | imm_dw;
            tcra_pkg::OP_XOR:  alu_res = rd_a_reg ^ rd_b_reg;
            tcra_pkg::OP_SLL:  alu_res = rd_a_reg << shamt;
            tcra_pkg::OP_SRL:  alu_res = rd_a_reg >> shamt;
            tcra_pkg::OP_LI:   alu_res = imm_dw;
            default:           alu_res = '0;
        endcase
    end

    // The multiplicand shifts up one slice per cycle while the multiplier
    // slices are taken in turn, so only the low product bits are formed.
    assign vb_wide   = WIDE_W'(rd_b_reg);
    assign chunk_sel = vb_wide[chunk_reg * MC +: MC];
    assign prod      = mcand_reg * chunk_sel;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        dump_idx_next   = dump_idx_reg;
        chunk_next      = chunk_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        mcand_next      = mcand_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = clr_cnt_reg;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        out_load        = 1'b0;
        out_status_next = tcra_pkg::STATUS_EXEC;
        out_index_next  = '0;
        out_value_next  = '0;
        out_last_next   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    case (q_head.kind)
                        tcra_pkg::KIND_WRITE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr_a  = rf_addr(q_head.ctx, RIW'(q_head.src_a));
                            rd_addr_b  = rf_addr(q_head.ctx, RIW'(q_head.src_b));
                            state_next = S_EXEC;
                        end
                        tcra_pkg::KIND_DUMP:
                        begin
                            rd_en         = 1'b1;
                            rd_addr_a     = rf_addr(q_head.ctx, '0);
                            rd_addr_b     = rd_addr_a;
                            dump_idx_next = '0;
                            state_next    = S_DUMP;
                        end
                        default:
                        begin
                            state_next = S_WB;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                if (cur_reg.op == tcra_pkg::OP_MUL)
                begin
                    mcand_next = rd_a_reg;
                    res_next   = '0;
                    chunk_next = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    res_next   = alu_res;
                    state_next = S_WB;
                end
            end
            S_MUL:
            begin
                res_next   = res_reg + prod[DATA_WIDTH-1:0];
                mcand_next = mcand_reg << MC;
                if (chunk_reg == LAST_CHUNK)
                begin
                    state_next = S_WB;
                end
                else
                begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            S_WB:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (cur_reg.kind)
                        tcra_pkg::KIND_WRITE:
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = rf_addr(cur_reg.ctx, RIW'(cur_reg.dest));
                            mem_wdata      = res_reg;
                            out_index_next = cur_reg.dest;
                            out_value_next = WW'(res_reg);
                        end
                        tcra_pkg::KIND_BAD:
                        begin
                            out_status_next = tcra_pkg::STATUS_BAD;
                        end
                        default:
                        begin
                            out_status_next = tcra_pkg::STATUS_EXEC;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = tcra_pkg::STATUS_DUMP;
                    out_index_next  = IW'(dump_idx_reg);
                    out_value_next  = WW'(rd_a_reg);
                    out_last_next   = (dump_idx_reg == LAST_IDX);
                    if (dump_idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dump_idx_next = dump_idx_reg + 1'b1;
                        rd_en         = 1'b1;
                        rd_addr_a     = rf_addr(cur_reg.ctx, RIW'(dump_idx_reg + 1'b1));
                        rd_addr_b     = rd_addr_a;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dump_idx_reg <= dump_idx_next;
        chunk_reg    <= chunk_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        mcand_reg    <= mcand_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_index_reg  <= out_index_next;
            out_value_reg  <= out_value_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Register file: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rf_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= rf_mem[rd_addr_a];
            rd_b_reg <= rf_mem[rd_addr_b];
        end
    end

endmodule

>>> rtl/two_context_register_alu.sv
// Top level of the two-context register ALU: front end, instruction queue
// and back end. Depends on tcra_pkg, tcra_if, tcra_front, tcra_queue, tcra_back.
//
// This block executes decoded register instructions for NUM_CONTEXTS virtual
// machines, each owning NUM_REGS registers of DATA_WIDTH bits held in a single
// register file memory. Instruction transactions enter through the instr
// channel and are classified by the front end, which wraps the context and
// register indexes and pushes the result into a queue of QUEUE_DEPTH entries;
// the front end keeps taking transactions as long as the queue has room, even
// while a result waits on the result channel. The back end pops one entry at a
// time and works on it until its results are registered: a register-writing
// operation passes through pop with register file read, execute and write
// back, a multiply adds a multiply state in which the multiplier handles a
// 16-bit slice of the second operand per cycle, a no-op or unknown opcode
// goes from pop straight to write back, and a dump gives one result per
// register, one per cycle while the result channel takes them, read through
// read port a of the register file. The sustained rate is therefore set by
// the back end as long as the result channel does not stall; the back end
// takes no new entry before it is through with the last. After reset the
// back end sweeps the register file to zero, one entry per cycle over all
// NUM_CONTEXTS * NUM_REGS entries (64 at the default configuration); no
// instruction transaction is taken during that pass. Each result transaction
// carries a status (executed, dump value or unknown instruction), a register
// index, a value and a last flag that marks the final result caused by an
// instruction. Results stay in the output register until the result channel
// takes them.
module two_context_register_alu #(
    parameter int NUM_REGS     = tcra_pkg::DEF_NUM_REGS,
    parameter int NUM_CONTEXTS = tcra_pkg::DEF_NUM_CONTEXTS,
    parameter int DATA_WIDTH   = tcra_pkg::DEF_DATA_WIDTH,
    parameter int QUEUE_DEPTH  = tcra_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    tcra_in_if.sink     instr,
    tcra_out_if.source  result
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic              clearing;
    tcra_pkg::entry_t  push_entry;
    tcra_pkg::entry_t  q_head;

    // Classification and index wrapping of incoming transactions.
    tcra_front #(
        .NUM_REGS     (NUM_REGS),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_front (
        .instr      (instr),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (q_push),
        .push_entry (push_entry)
    );

    // The queue lets the front end keep accepting while the back end is busy.
    tcra_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // Execution, register file and result delivery.
    tcra_back #(
        .NUM_REGS     (NUM_REGS),
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .result   (result)
    );

`ifndef ASSERT_OFF
    // The back end never takes an entry from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // No result is offered while the register file is still being cleared.
    a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !result.valid)
        else $error("result offered during register file clear");

    // An accepted transaction is held in the queue in the following cycle.
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |=> !q_empty)
        else $error("accepted transaction missing from queue");
`endif

endmodule

>>> tb/two_context_register_alu_test.sv
// Testbench for two_context_register_alu: directed and random instruction streams,
// checked result by result against a register-file scoreboard with its own predictor.
// Depends on tcra_pkg, the tcra_in_if and tcra_out_if interfaces and the RTL top level.

typedef struct {
    logic [tcra_pkg::OP_W-1:0]   op;
    logic                        ctx;
    logic [tcra_pkg::IDX_W-1:0]  dest;
    logic [tcra_pkg::IDX_W-1:0]  src_a;
    logic [tcra_pkg::IDX_W-1:0]  src_b;
    logic [tcra_pkg::WORD_W-1:0] imm;
} vm_instr_t;

typedef struct {
    logic [1:0]                  status;
    logic [tcra_pkg::IDX_W-1:0]  index;
    logic [tcra_pkg::WORD_W-1:0] value;
    logic                        last;
} vm_result_t;

// Keeps a private copy of both register files and the results that each
// accepted instruction should produce, in order.
class regfile_scoreboard;
    logic [tcra_pkg::WORD_W-1:0] vm_regs [tcra_pkg::DEF_NUM_CONTEXTS][tcra_pkg::DEF_NUM_REGS];
    vm_result_t                  expected_q [$];
    int unsigned                 mismatches;
    int unsigned                 report_limit;

    function new();
        foreach (vm_regs[c, r])
            vm_regs[c][r] = '0;
        mismatches   = 0;
        report_limit = 10;
    endfunction

    function void push_result(logic [1:0] st, logic [tcra_pkg::IDX_W-1:0] idx,
                              logic [tcra_pkg::WORD_W-1:0] val, logic lst);
        vm_result_t res;
        res.status = st;
        res.index  = idx;
        res.value  = val;
        res.last   = lst;
        expected_q.insert(expected_q.size(), res);
    endfunction

    function void note_instruction(vm_instr_t it);
        logic [tcra_pkg::WORD_W-1:0] va;
        logic [tcra_pkg::WORD_W-1:0] vb;
        logic [tcra_pkg::WORD_W-1:0] r;
        logic [4:0]                  sh;
        bit                          writes;
        va     = vm_regs[it.ctx][it.src_a];
        vb     = vm_regs[it.ctx][it.src_b];
        sh     = it.imm[4:0];
        r      = '0;
        writes = 1'b1;
        case (it.op)
            tcra_pkg::OP_ADD:  r = va + vb;
            tcra_pkg::OP_ADDI: r = va + it.imm;
            tcra_pkg::OP_SUB:  r = va - vb;
            tcra_pkg::OP_MUL:  r = va * vb;
            tcra_pkg::OP_AND:  r = va & vb;
            tcra_pkg::OP_OR:   r = va | vb;
            tcra_pkg::OP_ORI:  r = va | it.imm;
            tcra_pkg::OP_XOR:  r = va ^ vb;
            tcra_pkg::OP_SLL:  r = va << sh;
            tcra_pkg::OP_SRL:  r = va >> sh;
            tcra_pkg::OP_LI:   r = it.imm;
            tcra_pkg::OP_DUMP:
            begin
                writes = 1'b0;
                for (int i = 0; i < tcra_pkg::DEF_NUM_REGS; i++)
                    push_result(tcra_pkg::STATUS_DUMP, tcra_pkg::IDX_W'(i),
                                vm_regs[it.ctx][i], i == tcra_pkg::DEF_NUM_REGS - 1);
            end
            tcra_pkg::OP_NOP:
            begin
                writes = 1'b0;
                push_result(tcra_pkg::STATUS_EXEC, '0, '0, 1'b1);
            end
            default:
            begin
                writes = 1'b0;
                push_result(tcra_pkg::STATUS_BAD, '0, '0, 1'b1);
            end
        endcase
        if (writes)
        begin
            vm_regs[it.ctx][it.dest] = r;
            push_result(tcra_pkg::STATUS_EXEC, it.dest, r, 1'b1);
        end
    endfunction

    function void complain(string what);
        mismatches++;
        if (mismatches <= report_limit)
            $display("%0t: mismatch: %s", $realtime, what);
    endfunction

    function void check_result(logic [1:0] st, logic [tcra_pkg::IDX_W-1:0] idx,
                               logic [tcra_pkg::WORD_W-1:0] val, logic lst);
        vm_result_t want;
        if (expected_q.size() == 0)
        begin
            complain($sformatf("unexpected result st=%0d idx=%0d val=%h last=%b",
                               st, idx, val, lst));
            return;
        end
        want = expected_q.pop_front();
        if (want.status !== st || want.index !== idx || want.value !== val
            || want.last !== lst)
            complain($sformatf({"expected st=%0d idx=%0d val=%h last=%b, ",
                                "got st=%0d idx=%0d val=%h last=%b"},
                               want.status, want.index, want.value, want.last,
                               st, idx, val, lst));
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module two_context_register_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 300;
    // Receiver hold-off: after this many accepted instructions the result
    // channel is stalled long enough for the queue to fill and stall the input.
    localparam int HOLD_AT      = 140;
    localparam int HOLD_CYCLES  = 300;
    // Time left after the last expected result so that any stray extra result
    // still has a chance to show up before the verdict.
    localparam int DRAIN_CYCLES = 60;
    // Far beyond the slowest legal run, even if every item were a dump
    // drained through the slowest stall pattern.
    localparam longint TIMEOUT_NS = 10_000_000;

    // Opcodes 13 through 15 have no name in the package; they must be
    // reported as unknown instructions.
    localparam logic [tcra_pkg::OP_W-1:0] OP_BAD_FIRST = 4'd13;
    localparam logic [tcra_pkg::OP_W-1:0] OP_BAD_LAST  = 4'd15;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tcra_in_if  instr_ch ();
    tcra_out_if result_ch ();

    two_context_register_alu dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    regfile_scoreboard board = new();

    // Number of instruction transactions accepted so far; the receiver uses
    // it to decide when to start its long hold-off.
    int unsigned items_sent = 0;

    always #(HALF_PERIOD) clk = ~clk;

    // The run is cut short here if the block ever stops delivering results.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", board.pending());
        $display("status: fail");
        $finish;
    end

    function automatic vm_instr_t make_instr(logic [tcra_pkg::OP_W-1:0] op, logic ctx,
                                             int d, int a, int b,
                                             logic [tcra_pkg::WORD_W-1:0] imm);
        vm_instr_t it;
        it.op    = op;
        it.ctx   = ctx;
        it.dest  = tcra_pkg::IDX_W'(d);
        it.src_a = tcra_pkg::IDX_W'(a);
        it.src_b = tcra_pkg::IDX_W'(b);
        it.imm   = imm;
        return it;
    endfunction

    // Register indexes are drawn from a small pool most of the time so that
    // results feed later instructions and values grow beyond the immediates.
    function automatic logic [tcra_pkg::IDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) < 6)
            return tcra_pkg::IDX_W'($urandom_range(0, 7));
        return tcra_pkg::IDX_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [tcra_pkg::WORD_W-1:0] pick_immediate();
        logic [tcra_pkg::WORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = 32'($urandom_range(0, 31)) - 32'd16;
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = $urandom & 32'h0000_FFFF;
        endcase
        return v;
    endfunction

    // Weighted mix: mostly register-writing operations so that the files
    // hold interesting values, with occasional dumps, no-ops and bad codes.
    function automatic vm_instr_t random_instr();
        vm_instr_t it;
        int        pick;
        pick     = $urandom_range(0, 99);
        it.ctx   = 1'($urandom_range(0, 1));
        it.dest  = pick_index();
        it.src_a = pick_index();
        it.src_b = pick_index();
        it.imm   = pick_immediate();
        if (pick < 14)      it.op = tcra_pkg::OP_LI;
        else if (pick < 20) it.op = tcra_pkg::OP_ADDI;
        else if (pick < 26) it.op = tcra_pkg::OP_ADD;
        else if (pick < 32) it.op = tcra_pkg::OP_SUB;
        else if (pick < 40) it.op = tcra_pkg::OP_MUL;
        else if (pick < 46) it.op = tcra_pkg::OP_AND;
        else if (pick < 52) it.op = tcra_pkg::OP_OR;
        else if (pick < 58) it.op = tcra_pkg::OP_ORI;
        else if (pick < 64) it.op = tcra_pkg::OP_XOR;
        else if (pick < 72) it.op = tcra_pkg::OP_SLL;
        else if (pick < 80) it.op = tcra_pkg::OP_SRL;
        else if (pick < 86) it.op = tcra_pkg::OP_DUMP;
        else if (pick < 92) it.op = tcra_pkg::OP_NOP;
        else                it.op = tcra_pkg::OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        return it;
    endfunction

    // Offers one instruction transaction and waits for the edge that takes it.
    // Valid is left high afterwards; the caller lowers it when a gap follows,
    // so a back-to-back transaction never sees valid dropped and raised in
    // the same time step.
    task automatic send_instr(input vm_instr_t it);
        instr_ch.valid       <= 1'b1;
        instr_ch.op          <= it.op;
        instr_ch.context_req <= it.ctx;
        instr_ch.dest_reg    <= it.dest;
        instr_ch.src_a_reg   <= it.src_a;
        instr_ch.src_b_reg   <= it.src_b;
        instr_ch.immediate   <= it.imm;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        board.note_instruction(it);
        items_sent++;
    endtask

    // Sends the whole list in bursts of random length. Some bursts are long
    // stretches with no idling; after a burst valid usually drops for a random
    // gap, so that gaps land on every phase of the back end. Valid may be
    // left high at the end so that the next list follows without a gap.
    task automatic send_all(ref vm_instr_t stim [$]);
        int pos;
        int burst;
        pos = 0;
        while (pos < stim.size())
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
            while (burst > 0 && pos < stim.size())
            begin
                send_instr(stim[pos]);
                pos++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                instr_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Result side. Every accepted result transaction is checked against the
    // oldest expectation. Ready follows an 8-bit pattern that is rotated each
    // cycle and replaced at random intervals (all ones now and then), and
    // once in the run it stays low for a long stretch.
    initial
    begin : result_sink
        logic [7:0] stall_pattern;
        int         phase;
        int         pattern_left;
        int         hold_left;
        bit         held_once;
        stall_pattern   = 8'hFF;
        phase           = 0;
        pattern_left    = 40;
        hold_left       = 0;
        held_once       = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                board.check_result(result_ch.status, result_ch.reg_index,
                                   result_ch.reg_value, result_ch.last);
            if (!held_once && items_sent >= HOLD_AT)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (pattern_left == 0)
            begin
                stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF
                                                            : 8'($urandom_range(1, 255));
                pattern_left  = $urandom_range(10, 120);
            end
            else
                pattern_left--;
            phase = (phase + 1) % 8;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= stall_pattern[phase];
        end
    end

    initial
    begin : stimulus
        vm_instr_t directed [$];
        vm_instr_t randomized [$];

        // Known values on every input from time zero; reset is held low from the
        // start and released once.
        instr_ch.valid       <= 1'b0;
        instr_ch.op          <= '0;
        instr_ch.context_req <= 1'b0;
        instr_ch.dest_reg    <= '0;
        instr_ch.src_a_reg   <= '0;
        instr_ch.src_b_reg   <= '0;
        instr_ch.immediate   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme values loaded into both contexts, then every
        // operation on them, including signed overflow and wrap-around, shift
        // amounts whose upper immediate bits must be ignored, a shift right
        // that must not carry the sign bit in, a write to register zero, a
        // no-op, unknown opcodes and a dump of each context, which also shows
        // that the two files stay apart. The block accepts nothing until its
        // clearing pass after reset is done; the handshake takes care of that.
        directed = {
            make_instr(tcra_pkg::OP_LI,   1'b0,  1,  0,  0, 32'h7FFF_FFFF),
            make_instr(tcra_pkg::OP_LI,   1'b0,  2,  0,  0, 32'h8000_0000),
            make_instr(tcra_pkg::OP_LI,   1'b1, 31,  0,  0, 32'hFFFF_FFFF),
            make_instr(tcra_pkg::OP_LI,   1'b1, 30,  0,  0, 32'h0001_0001),
            make_instr(tcra_pkg::OP_ADD,  1'b0,  3,  1,  1, 32'h0),
            make_instr(tcra_pkg::OP_ADDI, 1'b0,  4,  2,  0, 32'hFFFF_FFFF),
            make_instr(tcra_pkg::OP_SUB,  1'b0,  5,  2,  1, 32'h0),
            make_instr(tcra_pkg::OP_SUB,  1'b0,  0,  0,  1, 32'h0),
            make_instr(tcra_pkg::OP_MUL,  1'b1, 29, 31, 30, 32'h0),
            make_instr(tcra_pkg::OP_MUL,  1'b0,  6,  1,  2, 32'h0),
            make_instr(tcra_pkg::OP_AND,  1'b1, 28, 31, 30, 32'h0),
            make_instr(tcra_pkg::OP_OR,   1'b0,  7,  1,  2, 32'h0),
            make_instr(tcra_pkg::OP_ORI,  1'b1, 27,  0,  0, 32'h8000_0000),
            make_instr(tcra_pkg::OP_XOR,  1'b0,  8,  1, 31, 32'h0),
            make_instr(tcra_pkg::OP_SLL,  1'b0,  9,  1,  0, 32'hFFFF_FFE1),
            make_instr(tcra_pkg::OP_SLL,  1'b1, 10, 31,  0, 32'h0000_001F),
            make_instr(tcra_pkg::OP_SRL,  1'b0, 11,  2,  0, 32'h0000_001F),
            make_instr(tcra_pkg::OP_SRL,  1'b1, 12, 31,  0, 32'h0000_0020),
            make_instr(tcra_pkg::OP_NOP,  1'b1, 31, 31, 31, 32'hFFFF_FFFF),
            make_instr(OP_BAD_FIRST,      1'b0,  5,  1,  2, 32'h1234_5678),
            make_instr(OP_BAD_LAST,       1'b1, 31, 31, 31, 32'hFFFF_FFFF),
            make_instr(tcra_pkg::OP_DUMP, 1'b0,  0,  0,  0, 32'h0),
            make_instr(tcra_pkg::OP_DUMP, 1'b1, 31, 31, 31, 32'hFFFF_FFFF)
        };
        send_all(directed);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            randomized.insert(randomized.size(), random_instr());
        send_all(randomized);
        instr_ch.valid <= 1'b0;

        // Let every expected result arrive, then give the block time to show
        // any stray extra result before the verdict.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/tcra_pkg.sv
rtl/tcra_if.sv
rtl/tcra_front.sv
rtl/tcra_queue.sv
rtl/tcra_back.sv
rtl/two_context_register_alu.sv
tb/two_context_register_alu_test.sv
